// ===== src/rmth_pkg.sv =====
// ----------------------------------------------------------------------------
// Running median package
// Shared sizes, widths and the heap ordering function.
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int HEAP_DEPTH = 512;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int SIZE_W     = ADDR_W + 1;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 10;
  localparam int MAX_TOTAL  = 2 * HEAP_DEPTH - 1;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [SIZE_W-1:0] size_t;

  // True when a belongs above b: the min-heap wants smaller, the max-heap larger.
  function automatic logic goes_first(input val_t a, input val_t b, input logic is_min);
    goes_first = is_min ? (a < b) : (a > b);
  endfunction

endpackage

// ===== src/rmth_if.sv =====
// ----------------------------------------------------------------------------
// Running median channels
// Valid/ready channels for the sample requests and the median results.
// ----------------------------------------------------------------------------
interface rmth_in_if import rmth_pkg::*; ();
  logic valid;
  logic ready;
  val_t value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rmth_out_if import rmth_pkg::*; ();
  logic valid;
  logic ready;
  val_t median;
  cnt_t count;
  logic dropped;
  modport source (output valid, output median, output count, output dropped, input ready);
  modport sink   (input valid, input median, input count, input dropped, output ready);
endinterface

// ===== src/running_median_two_heap.sv =====
// ----------------------------------------------------------------------------
// Running median over two heaps
// Max-heap of the lower half and min-heap of the upper half in two RAMs.
// ----------------------------------------------------------------------------
// One request is handled at a time. An insert sifts up one heap level at a time
// through the RAM read port; a rebalance adds a sift-down, which reads both
// children of each level, plus a second sift-up, so a rebalanced item takes
// two sift-ups and one sift-down over up to eight levels each at a depth of 512.
// A full store (1023 samples) drops the request. The result waits in an output
// register; the next request is taken while it is pending, and the block only
// stalls when a second result is ready before the first one has been taken.
module running_median_two_heap import rmth_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  rmth_in_if.sink       in_chan,
  rmth_out_if.source    out_chan
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_INS_CHK = 10'b0000000010,
    S_INS_CMP = 10'b0000000100,
    S_BAL     = 10'b0000001000,
    S_REM_LD  = 10'b0000010000,
    S_REM_CHK = 10'b0000100000,
    S_REM_L   = 10'b0001000000,
    S_REM_R   = 10'b0010000000,
    S_REM_CMP = 10'b0100000000,
    S_FIN     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  size_t  lo_sz_r, lo_sz_nxt, up_sz_r, up_sz_nxt;
  val_t   top_lo_r, top_up_r;
  logic   sel_r, sel_nxt;      // 1: upper min-heap, 0: lower max-heap
  logic   phase_r, phase_nxt;  // 1: the insert that follows a rebalance removal
  val_t   x_r, x_nxt, m_r, m_nxt, a_r, a_nxt;
  addr_t  i_r, i_nxt, c_r, c_nxt;
  logic   drop_r, drop_nxt;
  logic   out_valid_r;
  val_t   out_median_r;
  cnt_t   out_count_r;
  logic   out_dropped_r;

  logic  we;
  addr_t waddr, raddr;
  val_t  wdata, lo_rd, up_rd, rd;

  logic [SIZE_W:0] total;
  size_t cur_sz, lchild, rchild;
  addr_t parent;
  val_t  ltop, utop;
  logic  out_free;

  rmth_ram #(.WIDTH(VAL_W), .DEPTH(HEAP_DEPTH)) u_lo_ram (
    .clk(clk), .we(we && !sel_r), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(lo_rd)
  );

  rmth_ram #(.WIDTH(VAL_W), .DEPTH(HEAP_DEPTH)) u_up_ram (
    .clk(clk), .we(we && sel_r), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(up_rd)
  );

  assign rd       = sel_r ? up_rd : lo_rd;
  assign total    = {1'b0, lo_sz_r} + {1'b0, up_sz_r};
  assign cur_sz   = sel_r ? up_sz_r : lo_sz_r;
  assign lchild   = {i_r, 1'b1};
  assign rchild   = lchild + size_t'(1);
  assign parent   = (i_r - addr_t'(1)) >> 1;
  assign ltop     = (lo_sz_r != '0) ? top_lo_r : '0;
  assign utop     = (up_sz_r != '0) ? top_up_r : '1;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready    = (state_r == S_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.median  = out_median_r;
  assign out_chan.count   = out_count_r;
  assign out_chan.dropped = out_dropped_r;

  always_comb begin
    state_nxt = state_r;
    lo_sz_nxt = lo_sz_r;
    up_sz_nxt = up_sz_r;
    sel_nxt   = sel_r;
    phase_nxt = phase_r;
    x_nxt     = x_r;
    m_nxt     = m_r;
    a_nxt     = a_r;
    i_nxt     = i_r;
    c_nxt     = c_r;
    drop_nxt  = drop_r;
    we        = 1'b0;
    waddr     = i_r;
    wdata     = x_r;
    raddr     = parent;
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          if (total >= (SIZE_W+1)'(MAX_TOTAL)) begin
            drop_nxt  = 1'b1;
            state_nxt = S_FIN;
          end else begin
            drop_nxt  = 1'b0;
            x_nxt     = in_chan.value;
            phase_nxt = 1'b0;
            state_nxt = S_INS_CHK;
            if (in_chan.value >= utop) begin
              sel_nxt   = 1'b1;
              i_nxt     = up_sz_r[ADDR_W-1:0];
              up_sz_nxt = up_sz_r + size_t'(1);
            end else begin
              sel_nxt   = 1'b0;
              i_nxt     = lo_sz_r[ADDR_W-1:0];
              lo_sz_nxt = lo_sz_r + size_t'(1);
            end
          end
        end
      end
      S_INS_CHK: begin
        if (i_r == '0) begin
          we        = 1'b1;
          state_nxt = phase_r ? S_FIN : S_BAL;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (goes_first(x_r, rd, sel_r)) begin
          wdata     = rd;
          i_nxt     = parent;
          state_nxt = S_INS_CHK;
        end else begin
          state_nxt = phase_r ? S_FIN : S_BAL;
        end
      end
      S_BAL: begin
        if (up_sz_r == lo_sz_r + size_t'(2)) begin
          sel_nxt   = 1'b1;
          m_nxt     = top_up_r;
          up_sz_nxt = up_sz_r - size_t'(1);
          raddr     = up_sz_nxt[ADDR_W-1:0];
          state_nxt = S_REM_LD;
        end else if (lo_sz_r == up_sz_r + size_t'(2)) begin
          sel_nxt   = 1'b0;
          m_nxt     = top_lo_r;
          lo_sz_nxt = lo_sz_r - size_t'(1);
          raddr     = lo_sz_nxt[ADDR_W-1:0];
          state_nxt = S_REM_LD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_REM_LD: begin
        x_nxt     = rd;
        i_nxt     = '0;
        state_nxt = S_REM_CHK;
      end
      S_REM_CHK: begin
        raddr = lchild[ADDR_W-1:0];
        if (lchild >= cur_sz) begin
          we = 1'b1;
          // The hole is settled; the removed top now goes into the other heap.
          sel_nxt   = !sel_r;
          x_nxt     = m_r;
          phase_nxt = 1'b1;
          state_nxt = S_INS_CHK;
          if (sel_r) begin
            i_nxt     = lo_sz_r[ADDR_W-1:0];
            lo_sz_nxt = lo_sz_r + size_t'(1);
          end else begin
            i_nxt     = up_sz_r[ADDR_W-1:0];
            up_sz_nxt = up_sz_r + size_t'(1);
          end
        end else begin
          state_nxt = S_REM_L;
        end
      end
      S_REM_L: begin
        a_nxt = rd;
        c_nxt = lchild[ADDR_W-1:0];
        raddr = rchild[ADDR_W-1:0];
        state_nxt = (rchild < cur_sz) ? S_REM_R : S_REM_CMP;
      end
      S_REM_R: begin
        if (goes_first(rd, a_r, sel_r)) begin
          a_nxt = rd;
          c_nxt = rchild[ADDR_W-1:0];
        end
        state_nxt = S_REM_CMP;
      end
      S_REM_CMP: begin
        we = 1'b1;
        if (goes_first(a_r, x_r, sel_r)) begin
          wdata     = a_r;
          i_nxt     = c_r;
          state_nxt = S_REM_CHK;
        end else begin
          sel_nxt   = !sel_r;
          x_nxt     = m_r;
          phase_nxt = 1'b1;
          state_nxt = S_INS_CHK;
          if (sel_r) begin
            i_nxt     = lo_sz_r[ADDR_W-1:0];
            lo_sz_nxt = lo_sz_r + size_t'(1);
          end else begin
            i_nxt     = up_sz_r[ADDR_W-1:0];
            up_sz_nxt = up_sz_r + size_t'(1);
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lo_sz_r     <= '0;
      up_sz_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lo_sz_r <= lo_sz_nxt;
      up_sz_r <= up_sz_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sel_r   <= sel_nxt;
    phase_r <= phase_nxt;
    x_r     <= x_nxt;
    m_r     <= m_nxt;
    a_r     <= a_nxt;
    i_r     <= i_nxt;
    c_r     <= c_nxt;
    drop_r  <= drop_nxt;
    // Mirror the root of each heap so the tops need no RAM read.
    if (we && waddr == '0) begin
      if (sel_r) begin
        top_up_r <= wdata;
      end else begin
        top_lo_r <= wdata;
      end
    end
    if (state_r == S_FIN && out_free) begin
      out_count_r   <= total[CNT_W-1:0];
      out_dropped_r <= drop_r;
      if (up_sz_r > lo_sz_r) begin
        out_median_r <= utop;
      end else if (lo_sz_r > up_sz_r) begin
        out_median_r <= ltop;
      end else begin
        out_median_r <= val_t'(({1'b0, ltop} + {1'b0, utop}) >> 1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_balanced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (lo_sz_r <= up_sz_r + size_t'(1) && up_sz_r <= lo_sz_r + size_t'(1)))
    else $error("heap sizes differ by more than one at rest");
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total <= (SIZE_W+1)'(MAX_TOTAL))
    else $error("store holds more samples than allowed");
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> out_valid_r)
    else $error("finished request did not produce a result");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r != S_IDLE))
    else $error("accepted request left the block idle");
`endif

endmodule

// ===== src/rmth_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rmth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
